// ----- rtl/core/abn_pkg.sv -----
// Shared types and constants for the abundance classifier.
// Used by abn_ctrl, abn_dp and abundance_classifier; no dependencies.
package abn_pkg;

  localparam int SUM_W = 23;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TWO,
    ST_MUL_TWO,
    ST_CHECK,
    ST_DIV,
    ST_TERM,
    ST_MUL_ODD,
    ST_FINAL,
    ST_MUL_LAST,
    ST_DONE
  } abn_state_t;

  typedef struct packed {
    logic load;           // take a new value, reset the factoring registers
    logic two_step;       // strip one factor of 2
    logic div_start;      // start rest / cand
    logic div_step;       // one restoring-division step
    logic div_accept;     // rest <= quotient, pw <= pw * cand
    logic term_add;       // term <= term + pw
    logic mul_start;      // total * term, serial
    logic mul_start_rest; // total * (rest + 1), serial
    logic mul_step;
    logic mul_commit;     // total <= product, term/pw back to 1
    logic next_cand;      // cand += 2, square updated
    logic out_load;       // latch result into output register
  } abn_cmd_t;

  typedef struct packed {
    logic value_zero;
    logic rest_odd;
    logic sq_le_rest;
    logic div_done;
    logic rem_zero;
    logic term_gt1;
    logic mul_done;
    logic rest_gt1;
    logic out_busy;
  } abn_sts_t;

endpackage

// ----- rtl/core/abn_ctrl.sv -----
// Sequencer for the abundance classifier: trial-division state machine.
// Depends on abn_pkg; drives commands to abn_dp and reads its status.
module abn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  abn_pkg::abn_sts_t sts,
  output abn_pkg::abn_cmd_t cmd
);
  import abn_pkg::*;

  abn_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.value_zero ? ST_DONE : ST_TWO;
        end
      end
      ST_TWO: begin
        if (!sts.rest_odd) begin
          cmd.two_step = 1'b1;
        end else if (sts.term_gt1) begin
          cmd.mul_start = 1'b1;
          state_next    = ST_MUL_TWO;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_MUL_TWO: begin
        if (sts.mul_done) begin
          cmd.mul_commit = 1'b1;
          state_next     = ST_CHECK;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ST_CHECK: begin
        if (sts.sq_le_rest) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_FINAL;
        end
      end
      ST_DIV: begin
        if (!sts.div_done) begin
          cmd.div_step = 1'b1;
        end else if (sts.rem_zero) begin
          cmd.div_accept = 1'b1;
          state_next     = ST_TERM;
        end else if (sts.term_gt1) begin
          cmd.mul_start = 1'b1;
          state_next    = ST_MUL_ODD;
        end else begin
          cmd.next_cand = 1'b1;
          state_next    = ST_CHECK;
        end
      end
      ST_TERM: begin
        // divides again: keep stripping this prime
        cmd.term_add  = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_MUL_ODD: begin
        if (sts.mul_done) begin
          cmd.mul_commit = 1'b1;
          cmd.next_cand  = 1'b1;
          state_next     = ST_CHECK;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ST_FINAL: begin
        // leftover rest above 1 is a prime
        if (sts.rest_gt1) begin
          cmd.mul_start_rest = 1'b1;
          state_next         = ST_MUL_LAST;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MUL_LAST: begin
        if (sts.mul_done) begin
          cmd.mul_commit = 1'b1;
          state_next     = ST_DONE;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/abn_dp.sv -----
// Datapath for the abundance classifier: rest/candidate registers, serial
// divider, serial multiplier for sigma, and the output register.
// Depends on abn_pkg; controlled by abn_ctrl.
module abn_dp #(
  parameter int VALUE_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [VALUE_BITS-1:0]      value,
  input  abn_pkg::abn_cmd_t          cmd,
  output abn_pkg::abn_sts_t          sts,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [abn_pkg::SUM_W-1:0]  proper_divisor_sum,
  output logic                       abundant
);
  import abn_pkg::*;

  localparam int CAND_W = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_W   = VALUE_BITS + 2;
  localparam int TERM_W = VALUE_BITS + 1;
  localparam int TOT_W  = VALUE_BITS + 3;
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int CMP_W  = (TOT_W > SUM_W) ? TOT_W : SUM_W;
  localparam int PW_W   = VALUE_BITS + CAND_W;

  logic [VALUE_BITS-1:0] n;
  logic [VALUE_BITS-1:0] rest;
  logic [CAND_W-1:0]     cand;
  logic [SQ_W-1:0]       sq;        // cand * cand, kept incrementally
  logic [VALUE_BITS-1:0] pw;        // current prime power
  logic [TERM_W-1:0]     term;      // 1 + p + ... + p^k
  logic [TOT_W-1:0]      total;     // running sigma

  // restoring divider
  logic [VALUE_BITS-1:0] quo;
  logic [CAND_W-1:0]     rem;
  logic [CNT_W-1:0]      cnt;
  logic [CAND_W:0]       rem_sh;
  logic                  rem_ge;
  logic [CAND_W:0]       rem_diff;

  // shift-add multiplier
  logic [TERM_W-1:0]     mplier;
  logic [TOT_W-1:0]      mcand;
  logic [TOT_W-1:0]      prod;

  logic [PW_W-1:0]       pw_prod;
  logic [TOT_W-1:0]      sum;
  logic [CMP_W-1:0]      sum_ext;

  assign rem_sh   = {rem, quo[VALUE_BITS-1]};
  assign rem_ge   = rem_sh >= {1'b0, cand};
  assign rem_diff = rem_sh - {1'b0, cand};
  assign pw_prod  = PW_W'(pw) * PW_W'(cand);
  assign sum      = total - TOT_W'(n);
  assign sum_ext  = CMP_W'(sum);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n     <= value;
      rest  <= value;
      total <= (value == '0) ? '0 : TOT_W'(1);
      term  <= TERM_W'(1);
      pw    <= VALUE_BITS'(1);
      cand  <= CAND_W'(3);
      sq    <= SQ_W'(9);
    end else begin
      if (cmd.two_step) begin
        rest <= rest >> 1;
        pw   <= pw << 1;
        term <= term + (TERM_W'(pw) << 1);
      end
      if (cmd.div_accept) begin
        rest <= quo;
        pw   <= pw_prod[VALUE_BITS-1:0];
      end
      if (cmd.term_add) begin
        term <= term + TERM_W'(pw);
      end
      if (cmd.mul_commit) begin
        total <= prod;
        term  <= TERM_W'(1);
        pw    <= VALUE_BITS'(1);
      end
      if (cmd.next_cand) begin
        cand <= cand + CAND_W'(2);
        sq   <= sq + (SQ_W'(cand) << 2) + SQ_W'(4);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= rest;
      rem <= '0;
      cnt <= CNT_W'(VALUE_BITS);
    end else if (cmd.div_step) begin
      quo <= {quo[VALUE_BITS-2:0], rem_ge};
      rem <= rem_ge ? rem_diff[CAND_W-1:0] : rem_sh[CAND_W-1:0];
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start || cmd.mul_start_rest) begin
      mplier <= cmd.mul_start ? term : TERM_W'(rest) + TERM_W'(1);
      mcand  <= total;
      prod   <= '0;
    end else if (cmd.mul_step) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      abundant           <= sum > TOT_W'(n);
      proper_divisor_sum <= (sum_ext > CMP_W'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];
    end
  end

  always_comb begin
    sts.value_zero = (value == '0);
    sts.rest_odd   = rest[0];
    sts.sq_le_rest = sq <= SQ_W'(rest);
    sts.div_done   = (cnt == '0);
    sts.rem_zero   = (rem == '0);
    sts.term_gt1   = (term != TERM_W'(1));
    sts.mul_done   = (mplier == '0);
    sts.rest_gt1   = (rest > VALUE_BITS'(1));
    sts.out_busy   = out_valid && !out_ready;
  end

endmodule

// ----- rtl/core/abundance_classifier.sv -----
// Abundance classifier top level: aliquot sum and abundant flag per value.
// Instantiates abn_ctrl and abn_dp; depends on abn_pkg.
//
// Input channel (value, in_valid/in_ready) takes one unsigned integer per
// item; output channel (proper_divisor_sum, abundant, out_valid/out_ready)
// returns one result per item, in order. One item is worked at a time.
// The value is factored by trial division: factors of 2 are shifted out
// first, then odd candidates from 3 upward are tried while the candidate
// squared does not exceed the unfactored rest. Each candidate test runs the
// serial divider; each prime found costs a serial multiply. Run time thus
// grows with the square root of the unfactored rest. A zero value skips the
// factoring and goes straight to the output step with a zero result.
// The result sits in an output register: the next item is accepted while
// it waits, and a stalled receiver only holds the sequencer at its last
// step. Reset empties the output register and returns to idle; no other
// state survives between items.
module abundance_classifier #(
  parameter int VALUE_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [VALUE_BITS-1:0]      value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [abn_pkg::SUM_W-1:0]  proper_divisor_sum,
  output logic                       abundant
);
  import abn_pkg::*;

  abn_cmd_t cmd;
  abn_sts_t sts;

  abn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  abn_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .value              (value),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .proper_divisor_sum (proper_divisor_sum),
    .abundant           (abundant)
  );

  // an accepted item keeps the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("result overwritten before it was taken");

  // abundant implies a nonzero divisor sum
  a_abundant_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && abundant |-> proper_divisor_sum != '0)
    else $error("abundant flag with zero sum");

  // serial units are never started together
  a_one_start: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.div_start, cmd.mul_start, cmd.mul_start_rest}))
    else $error("conflicting start commands");

endmodule

// ----- verif/abn_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for abundance_classifier: watches both channels, predicts the
// aliquot sum and abundant flag of every accepted item and compares in order.
// Depends on abn_pkg for the result width and saturation value.
module abn_result_checker #(
  parameter int VALUE_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [VALUE_BITS-1:0]     value,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [abn_pkg::SUM_W-1:0] proper_divisor_sum,
  input  logic                      abundant,
  output int                        mismatches,
  output int                        results_owed
);

  typedef struct packed {
    logic [VALUE_BITS-1:0]     value;
    logic [abn_pkg::SUM_W-1:0] sum;
    logic                      abundant;
  } classified_t;

  classified_t due_q[$];

  // sigma(n) from the prime factorization, minus n; zero and one give zero
  function automatic classified_t classify(input logic [VALUE_BITS-1:0] v);
    classified_t      c;
    longint unsigned  n, rest, sigma, p, pk, part, aliquot;
    n     = v;
    rest  = n;
    sigma = 1;
    p     = 2;
    while (p * p <= rest) begin
      if (rest % p == 0) begin
        part = 1;
        pk   = 1;
        while (rest % p == 0) begin
          rest = rest / p;
          pk   = pk * p;
          part = part + pk;
        end
        sigma = sigma * part;
      end
      p = (p == 2) ? 3 : p + 2;
    end
    if (rest > 1) sigma = sigma * (rest + 1);
    aliquot    = (n == 0) ? 0 : sigma - n;
    c.value    = v;
    c.abundant = (aliquot > n);
    c.sum      = (aliquot > abn_pkg::SUM_MAX) ? abn_pkg::SUM_MAX
                                              : aliquot[abn_pkg::SUM_W-1:0];
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk) begin
    classified_t want;
    if (rst) begin
      due_q.delete();
      results_owed <= 0;
    end else begin
      if (in_valid && in_ready) due_q.insert(due_q.size(), classify(value));
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          report_mismatch($sformatf("result sum=%0d abundant=%0b with no item pending",
                                    proper_divisor_sum, abundant));
        end else begin
          want = due_q.pop_front();
          if (proper_divisor_sum !== want.sum)
            report_mismatch($sformatf("value %0d: proper_divisor_sum %0d, want %0d",
                                      want.value, proper_divisor_sum, want.sum));
          if (abundant !== want.abundant)
            report_mismatch($sformatf("value %0d: abundant %0b, want %0b",
                                      want.value, abundant, want.abundant));
        end
      end
      results_owed <= due_q.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the abundance_classifier testbench: clock, reset, stimulus phases
// and verdict. Depends on abn_pkg and abn_result_checker.
module tb_top;

  localparam int VALUE_BITS = 20;
  localparam int CYCLE_LIMIT = 6_000_000;

  localparam int N_CORNERS = 24;
  // zero, one, small perfect and abundant numbers, bit patterns, prime
  // squares and the slowest primes near the top of the range
  localparam logic [VALUE_BITS-1:0] CORNERS [N_CORNERS] = '{
    0, 1, 2, 3, 4, 6, 9, 12, 18, 25, 28, 945, 1024, 524288, 699050, 349525,
    720720, 510510, 1000000, 1042441, 524287, 1048574, 1048573, 1048575
  };
  localparam int SND_IDLE  [4] = '{0, 78, 0, 31};
  localparam int RCV_STALL [4] = '{0, 0, 78, 31};

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [VALUE_BITS-1:0]     value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [abn_pkg::SUM_W-1:0] proper_divisor_sum;
  logic                      abundant;

  int mismatches;
  int results_owed;
  int snd_idle = 0;
  int rcv_stall = 0;
  int cycles = 0;

  abundance_classifier #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk, .rst, .in_valid, .in_ready, .value,
    .out_valid, .out_ready, .proper_divisor_sum, .abundant
  );

  abn_result_checker #(.VALUE_BITS(VALUE_BITS)) u_check (
    .clk, .rst, .in_valid, .in_ready, .value,
    .out_valid, .out_ready, .proper_divisor_sum, .abundant,
    .mismatches, .results_owed
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else     out_ready <= ($urandom_range(99) >= rcv_stall);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // latency grows with sqrt of what is left after factoring, so most values
  // stay small; shifted small values still reach the high bits cheaply
  function automatic logic [VALUE_BITS-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 4)  return VALUE_BITS'($urandom());
    if (r < 16) return VALUE_BITS'($urandom_range(65535, 1));
    if (r < 30) return VALUE_BITS'($urandom_range(4095, 1) << $urandom_range(8, 0));
    if (r < 38) return VALUE_BITS'(12 * $urandom_range(300, 1));
    return VALUE_BITS'($urandom_range(4095, 1));
  endfunction

  // returns at the edge where the item is taken
  task automatic offer(input logic [VALUE_BITS-1:0] v);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      snd_idle  = SND_IDLE[ph];
      rcv_stall = RCV_STALL[ph];
      if (ph == 0)
        for (int i = 0; i < N_CORNERS; i++) offer(CORNERS[i]);
      for (int k = 0; k < 29; k++) offer(pick_value());
      // hold the sender until every result of this phase is back
      in_valid <= 1'b0;
      do @(posedge clk); while (results_owed != 0);
    end
    repeat (64) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
